>>> hdl/rsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;

    // exact intermediate widths of the quadratic
    localparam int A_W      = 33;   // P - C
    localparam int DD_W     = 64;   // D.D
    localparam int H_W      = 66;   // D.(P - C), signed
    localparam int C_W      = 67;   // |P - C|^2 - r^2, signed
    localparam int HMAG_W   = 65;
    localparam int CMAG_W   = 66;
    localparam int DISC_W   = 126;
    localparam int ROOT_W   = 79;   // sqrt of disc * 2^32
    localparam int NUM_W    = 82;   // |-(h * 2^16) - s|
    localparam int MUL_CHUNK = 16;

    localparam logic [COORD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0]  ray_origin_x;
        logic signed [COORD_W-1:0]  ray_origin_y;
        logic signed [COORD_W-1:0]  ray_origin_z;
        logic signed [COORD_W-1:0]  ray_dir_x;
        logic signed [COORD_W-1:0]  ray_dir_y;
        logic signed [COORD_W-1:0]  ray_dir_z;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_y;
        logic signed [COORD_W-1:0]  center_z;
        logic [RADIUS_W-1:0]        sphere_radius;
    } rsi_req_t;

    typedef struct packed {
        logic                       hit;
        logic signed [COORD_W-1:0]  hit_distance;
        logic signed [COORD_W-1:0]  contact_x;
        logic signed [COORD_W-1:0]  contact_y;
        logic signed [COORD_W-1:0]  contact_z;
        logic                       saturated;
    } rsi_res_t;

endpackage

`default_nettype wire

>>> hdl/rsi_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rsi_req_if import rsi_pkg::*; ();
    logic     valid;
    logic     ready;
    rsi_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/rsi_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rsi_res_if import rsi_pkg::*; ();
    logic     valid;
    logic     ready;
    rsi_res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/rsi_delay.sv
`timescale 1ns / 1ps
`default_nettype none

module rsi_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[N-1];

endmodule

`default_nettype wire

>>> hdl/rsi_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module rsi_mul #(
    parameter int WA = 65,
    parameter int WB = 65,
    parameter int CW = 16
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    output logic [WA+WB-1:0] p
);

    localparam int NC = (WB + CW - 1) / CW;
    localparam int BW = NC * CW;
    localparam int PW = WA + WB;

    logic [WA-1:0]    a_src   [NC];
    logic [WA-1:0]    a_reg   [NC];
    logic [BW-1:0]    b_src   [NC];
    logic [BW-1:0]    b_reg   [NC];
    logic [PW-1:0]    acc_src [NC];
    logic [PW-1:0]    acc_reg [NC];
    logic [WA+CW-1:0] part    [NC];

    genvar k;
    generate
        for (k = 0; k < NC; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                assign a_src[k]   = a;
                assign b_src[k]   = BW'(b);
                assign acc_src[k] = '0;
            end
            else
            begin : g_next
                assign a_src[k]   = a_reg[k-1];
                assign b_src[k]   = b_reg[k-1];
                assign acc_src[k] = acc_reg[k-1];
            end

            assign part[k] = {{CW{1'b0}}, a_src[k]} * {{WA{1'b0}}, b_src[k][k*CW +: CW]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[k]   <= a_src[k];
                    b_reg[k]   <= b_src[k];
                    acc_reg[k] <= acc_src[k] + (PW'(part[k]) << (k * CW));
                end
            end
        end
    endgenerate

    assign p = acc_reg[NC-1];

endmodule

`default_nettype wire

>>> hdl/rsi_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module rsi_sqrt #(
    parameter int RW = 79
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] rad,
    output logic [RW-1:0]   root
);

    logic [2*RW-1:0] rad_src  [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [RW+1:0]   rem_src  [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW+1:0]   rem_sh   [RW];
    logic [RW+1:0]   trial    [RW];
    logic [RW-1:0]   root_src [RW];
    logic [RW-1:0]   root_reg [RW];
    logic            ge       [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                assign rad_src[k]  = rad;
                assign rem_src[k]  = '0;
                assign root_src[k] = '0;
            end
            else
            begin : g_next
                assign rad_src[k]  = rad_reg[k-1];
                assign rem_src[k]  = rem_reg[k-1];
                assign root_src[k] = root_reg[k-1];
            end

            assign rem_sh[k] = {rem_src[k][RW-1:0], rad_src[k][2*RW-1 -: 2]};
            assign trial[k]  = {root_src[k], 2'b01};
            assign ge[k]     = (rem_sh[k] >= trial[k]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= rad_src[k] << 2;
                    rem_reg[k]  <= ge[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
                    root_reg[k] <= {root_src[k][RW-2:0], ge[k]};
                end
            end
        end
    endgenerate

    assign root = root_reg[RW-1];

endmodule

`default_nettype wire

>>> hdl/rsi_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rsi_div #(
    parameter int NW = 82,
    parameter int DW = 64
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic          rem_nz
);

    logic [NW-1:0] numq_src [NW];
    logic [NW-1:0] numq_reg [NW];
    logic [DW-1:0] rem_src  [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] den_src  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [DW:0]   rem_sh   [NW];
    logic [DW:0]   diff     [NW];
    logic          ge       [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                assign numq_src[k] = num;
                assign rem_src[k]  = '0;
                assign den_src[k]  = den;
            end
            else
            begin : g_next
                assign numq_src[k] = numq_reg[k-1];
                assign rem_src[k]  = rem_reg[k-1];
                assign den_src[k]  = den_reg[k-1];
            end

            assign rem_sh[k] = {rem_src[k], numq_src[k][NW-1]};
            assign diff[k]   = rem_sh[k] - {1'b0, den_src[k]};
            assign ge[k]     = (rem_sh[k] >= {1'b0, den_src[k]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    numq_reg[k] <= {numq_src[k][NW-2:0], ge[k]};
                    rem_reg[k]  <= ge[k] ? diff[k][DW-1:0] : rem_sh[k][DW-1:0];
                    den_reg[k]  <= den_src[k];
                end
            end
        end
    endgenerate

    assign quo    = numq_reg[NW-1];
    assign rem_nz = |rem_reg[NW-1];

endmodule

`default_nettype wire

>>> hdl/ray_sphere_intersection.sv
// Ray / sphere intersection in signed Q16.16, fully pipelined.
// req (sink) carries one request: ray origin, ray direction, sphere center
// and radius. rsp (source) returns one result per request, in order: hit,
// nearer root hit_distance, contact point and a saturated flag. A miss or a
// zero direction returns hit = 0 with all other fields zero.
// Throughput: one request per cycle while req.ready is high. Most of the
// depth lies in the 5-cell multiplier chains for the discriminant, the
// 79-cell square-root chain and the 82-cell divider chain; every cell is
// one stage.
// rsp is driven from an output register. When the receiver stalls, the
// pipeline keeps advancing while its last stage is empty, so requests are
// still taken until a finished result reaches the stage behind the output
// register; then req.ready drops until rsp.ready returns.
// Reset (rst_n low, asynchronous) clears all valid flags: the pipeline and
// output register come up empty and req.ready is high.
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_intersection import rsi_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    rsi_req_if.sink   req,
    rsi_res_if.source rsp
);

    localparam int MUL_LAT = (HMAG_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int LAT     = 11 + MUL_LAT + ROOT_W + NUM_W;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] p;
        logic [2:0][COORD_W-1:0] d;
    } ray_t;

    typedef struct packed {
        logic signed [H_W-1:0] h;
        logic [DD_W-1:0]       a;
        logic                  cneg;
        logic                  dz;
        ray_t                  ray;
    } side_mul_t;

    typedef struct packed {
        logic signed [H_W-1:0] h;
        logic [DD_W-1:0]       a;
        logic                  hit;
        ray_t                  ray;
    } side_sq_t;

    typedef struct packed {
        logic   nneg;
        logic   hit;
        ray_t   ray;
    } side_dv_t;

    logic           adv;
    logic [LAT-1:0] vld_reg;
    logic           out_valid_reg;
    rsi_res_t       out_reg;

    // stage 1
    logic signed [A_W-1:0]      a1_reg [3];
    ray_t                       ray1_reg;
    logic [RADIUS_W-1:0]        r1_reg;
    logic                       dz1_reg;
    // stage 2
    logic [DD_W-1:0]            dd2_reg [3];
    logic signed [H_W-2:0]      da2_reg [3];
    logic signed [CMAG_W-1:0]   aa2_reg [3];
    logic [2*RADIUS_W-1:0]      rr2_reg;
    ray_t                       ray2_reg;
    logic                       dz2_reg;
    // stage 3
    logic [DD_W-1:0]            a3_reg;
    logic signed [H_W-1:0]      h3_reg;
    logic signed [C_W-1:0]      c3_reg;
    ray_t                       ray3_reg;
    logic                       dz3_reg;
    // stage 4
    logic [HMAG_W-1:0]          habs4_reg;
    logic [CMAG_W-1:0]          cabs4_reg;
    side_mul_t                  side4_reg;
    // multiplier outputs
    logic [2*HMAG_W-1:0]        hh;
    logic [CMAG_W+HMAG_W-1:0]   ac;
    side_mul_t                  side_m;
    // stage 5
    logic [CMAG_W+HMAG_W-1:0]   disc_next;
    logic                       hit_next;
    logic [DISC_W-1:0]          disc5_reg;
    side_sq_t                   side5_reg;
    // root
    logic [ROOT_W-1:0]          root;
    side_sq_t                   side_s;
    // stages 6, 7
    logic signed [NUM_W:0]      n6_reg;
    side_sq_t                   side6_reg;
    logic [NUM_W-1:0]           nabs7_reg;
    logic [DD_W-1:0]            a7_reg;
    side_dv_t                   side7_reg;
    // divider outputs
    logic [NUM_W-1:0]           quo;
    logic                       rem_nz;
    side_dv_t                   side_d;
    // stages 8 - 11
    logic [NUM_W:0]             qs8_reg;
    logic                       hit8_reg;
    ray_t                       ray8_reg;
    logic                       qovf;
    logic signed [COORD_W-1:0]  tq9_reg;
    logic                       sat9_reg;
    logic                       hit9_reg;
    ray_t                       ray9_reg;
    logic signed [2*COORD_W-1:0] prod10_reg [3];
    logic signed [COORD_W-1:0]  tq10_reg;
    logic                       sat10_reg;
    logic                       hit10_reg;
    ray_t                       ray10_reg;
    logic [COORD_W+16:0]        sum11 [3];
    logic                       ovf11 [3];
    logic [COORD_W-1:0]         cp11  [3];
    rsi_res_t                   res11_reg;

    assign adv       = !vld_reg[LAT-1] || !out_valid_reg || rsp.ready;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[LAT-2:0], req.valid};
            end
            if (!out_valid_reg || rsp.ready)
            begin
                out_valid_reg <= vld_reg[LAT-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || rsp.ready)
        begin
            out_reg <= res11_reg;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // offsets, products, sums and magnitudes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg[0] <= A_W'(req.payload.ray_origin_x) - A_W'(req.payload.center_x);
            a1_reg[1] <= A_W'(req.payload.ray_origin_y) - A_W'(req.payload.center_y);
            a1_reg[2] <= A_W'(req.payload.ray_origin_z) - A_W'(req.payload.center_z);
            ray1_reg.p <= {req.payload.ray_origin_z, req.payload.ray_origin_y,
                           req.payload.ray_origin_x};
            ray1_reg.d <= {req.payload.ray_dir_z, req.payload.ray_dir_y,
                           req.payload.ray_dir_x};
            r1_reg  <= req.payload.sphere_radius;
            dz1_reg <= (req.payload.ray_dir_x == '0) && (req.payload.ray_dir_y == '0)
                       && (req.payload.ray_dir_z == '0);

            for (int k = 0; k < 3; k++)
            begin
                dd2_reg[k] <= $signed(ray1_reg.d[k]) * $signed(ray1_reg.d[k]);
                da2_reg[k] <= $signed(ray1_reg.d[k]) * a1_reg[k];
                aa2_reg[k] <= a1_reg[k] * a1_reg[k];
            end
            rr2_reg  <= r1_reg * r1_reg;
            ray2_reg <= ray1_reg;
            dz2_reg  <= dz1_reg;

            a3_reg   <= dd2_reg[0] + dd2_reg[1] + dd2_reg[2];
            h3_reg   <= H_W'(da2_reg[0]) + H_W'(da2_reg[1]) + H_W'(da2_reg[2]);
            c3_reg   <= C_W'(aa2_reg[0]) + C_W'(aa2_reg[1]) + C_W'(aa2_reg[2])
                        - $signed({{(C_W-2*RADIUS_W){1'b0}}, rr2_reg});
            ray3_reg <= ray2_reg;
            dz3_reg  <= dz2_reg;

            habs4_reg      <= h3_reg[H_W-1] ? HMAG_W'(-h3_reg) : HMAG_W'(h3_reg);
            cabs4_reg      <= c3_reg[C_W-1] ? CMAG_W'(-c3_reg) : CMAG_W'(c3_reg);
            side4_reg.h    <= h3_reg;
            side4_reg.a    <= a3_reg;
            side4_reg.cneg <= c3_reg[C_W-1];
            side4_reg.dz   <= dz3_reg;
            side4_reg.ray  <= ray3_reg;
        end
    end

    rsi_mul #(.WA(HMAG_W), .WB(HMAG_W), .CW(MUL_CHUNK)) u_mul_hh (
        .clk (clk),
        .en  (adv),
        .a   (habs4_reg),
        .b   (habs4_reg),
        .p   (hh)
    );

    rsi_mul #(.WA(CMAG_W), .WB(HMAG_W), .CW(MUL_CHUNK)) u_mul_ac (
        .clk (clk),
        .en  (adv),
        .a   (cabs4_reg),
        .b   ({1'b0, side4_reg.a}),
        .p   (ac)
    );

    rsi_delay #(.W($bits(side_mul_t)), .N(MUL_LAT)) u_dly_mul (
        .clk  (clk),
        .en   (adv),
        .din  (side4_reg),
        .dout (side_m)
    );

    always_comb
    begin
        if (side_m.cneg)
        begin
            disc_next = {1'b0, hh} + ac;
            hit_next  = !side_m.dz;
        end
        else
        begin
            disc_next = {1'b0, hh} - ac;
            hit_next  = !side_m.dz && ({1'b0, hh} >= ac);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            disc5_reg     <= disc_next[DISC_W-1:0];
            side5_reg.h   <= side_m.h;
            side5_reg.a   <= side_m.a;
            side5_reg.hit <= hit_next;
            side5_reg.ray <= side_m.ray;
        end
    end

    rsi_sqrt #(.RW(ROOT_W)) u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  ({disc5_reg, 32'd0}),
        .root (root)
    );

    rsi_delay #(.W($bits(side_sq_t)), .N(ROOT_W)) u_dly_sq (
        .clk  (clk),
        .en   (adv),
        .din  (side5_reg),
        .dout (side_s)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n6_reg    <= -$signed({side_s.h[H_W-1], side_s.h, 16'd0})
                         - $signed({{(NUM_W+1-ROOT_W){1'b0}}, root});
            side6_reg <= side_s;

            nabs7_reg      <= n6_reg[NUM_W] ? NUM_W'(-n6_reg) : NUM_W'(n6_reg);
            a7_reg         <= side6_reg.a;
            side7_reg.nneg <= n6_reg[NUM_W];
            side7_reg.hit  <= side6_reg.hit;
            side7_reg.ray  <= side6_reg.ray;
        end
    end

    rsi_div #(.NW(NUM_W), .DW(DD_W)) u_div (
        .clk    (clk),
        .en     (adv),
        .num    (nabs7_reg),
        .den    (a7_reg),
        .quo    (quo),
        .rem_nz (rem_nz)
    );

    rsi_delay #(.W($bits(side_dv_t)), .N(NUM_W)) u_dly_dv (
        .clk  (clk),
        .en   (adv),
        .din  (side7_reg),
        .dout (side_d)
    );

    assign qovf = !((&qs8_reg[NUM_W:COORD_W-1]) || !(|qs8_reg[NUM_W:COORD_W-1]));

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum11[k] = {{17{ray10_reg.p[k][COORD_W-1]}}, ray10_reg.p[k]}
                       + {prod10_reg[k][2*COORD_W-1], prod10_reg[k][2*COORD_W-1:16]};
            ovf11[k] = !((&sum11[k][COORD_W+16:COORD_W-1])
                         || !(|sum11[k][COORD_W+16:COORD_W-1]));
            cp11[k]  = ovf11[k] ? (sum11[k][COORD_W+16] ? Q_MIN : Q_MAX)
                                : sum11[k][COORD_W-1:0];
        end
    end

    // floor correction, clamp, contact point
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qs8_reg  <= side_d.nneg ? (~{1'b0, quo} + {{NUM_W{1'b0}}, !rem_nz})
                                    : {1'b0, quo};
            hit8_reg <= side_d.hit;
            ray8_reg <= side_d.ray;

            tq9_reg  <= qovf ? (qs8_reg[NUM_W] ? Q_MIN : Q_MAX) : qs8_reg[COORD_W-1:0];
            sat9_reg <= qovf;
            hit9_reg <= hit8_reg;
            ray9_reg <= ray8_reg;

            for (int k = 0; k < 3; k++)
            begin
                prod10_reg[k] <= $signed(ray9_reg.d[k]) * tq9_reg;
            end
            tq10_reg  <= tq9_reg;
            sat10_reg <= sat9_reg;
            hit10_reg <= hit9_reg;
            ray10_reg <= ray9_reg;

            if (hit10_reg)
            begin
                res11_reg.hit          <= 1'b1;
                res11_reg.hit_distance <= tq10_reg;
                res11_reg.contact_x    <= cp11[0];
                res11_reg.contact_y    <= cp11[1];
                res11_reg.contact_z    <= cp11[2];
                res11_reg.saturated    <= sat10_reg || ovf11[0] || ovf11[1] || ovf11[2];
            end
            else
            begin
                res11_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire
